FILE: hdl/blr_pkg.sv
package blr_pkg;

    // Canvas storage limits
    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 16;
    localparam int CELL_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

    // Field widths
    localparam int DOT_W     = 6;
    localparam int COL_W     = 5;
    localparam int ROW_W     = 4;
    localparam int PAT_W     = 8;
    localparam int COLS_W    = 6;
    localparam int ROWS_W    = 5;
    localparam int LIM_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_ROWS = 2'd1;

    // Braille dot bit for a dot within its 2x4 cell
    function automatic logic [PAT_W-1:0] braille_bit(input logic [1:0] sub_row,
                                                     input logic       right);
        logic [PAT_W-1:0] b;
        case (sub_row)
            2'd0:    b = right ? 8'h08 : 8'h01;
            2'd1:    b = right ? 8'h10 : 8'h02;
            2'd2:    b = right ? 8'h20 : 8'h04;
            2'd3:    b = right ? 8'h80 : 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/braille_line_rasterizer.sv
// Braille line rasterizer. A request on start/start_x..end_y (taken when start is
// high and busy is low) draws a Bresenham line between two dot positions; each
// dot is ORed into the braille pattern of its 2x4-dot character cell and
// reported as one result, valid high for exactly one cycle. The receiver cannot
// stall: results arrive one per cycle, in drawing order, and must be taken as
// they come. A line has N = max(|dx|,|dy|)+1 dots (1..64); busy stays high until
// its last dot has finished its update, and the next request is taken once busy
// is low. Each dot passes stage A, stage B and the output registers. The rate is
// set by the cell store's single read-modify-write per dot, overlapped one dot
// deep with a bypass for back-to-back hits on the same cell. After reset the
// block runs a clearing pass over all 512 cells (busy high) before it
// takes the first request; configuration writes are taken at any time but
// should only be issued while idle. Dots whose cell lies outside the canvas
// (canvas_cols x canvas_rows, capped at 32 x 16) are reported with written = 0
// and pattern = 0 and leave the store untouched.
module braille_line_rasterizer (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [blr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blr_pkg::CFG_DAT_W-1:0]   cfg_data,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [blr_pkg::DOT_W-1:0]       start_x,
    input  logic [blr_pkg::DOT_W-1:0]       start_y,
    input  logic [blr_pkg::DOT_W-1:0]       end_x,
    input  logic [blr_pkg::DOT_W-1:0]       end_y,
    // per-dot result
    output logic                            valid,
    output logic [blr_pkg::DOT_W-1:0]       dot_x,
    output logic [blr_pkg::DOT_W-1:0]       dot_y,
    output logic [blr_pkg::COL_W-1:0]       cell_col,
    output logic [blr_pkg::ROW_W-1:0]       cell_row,
    output logic [blr_pkg::PAT_W-1:0]       pattern,
    output logic                            written,
    output logic                            last
);
    import blr_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,   // zeroing the cell store after reset
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,   // stepping the line, one dot read per cycle
        ST_FLUSH = 4'b1000    // last dot finishing its update
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;

    // clearing pass
    logic [CELL_AW-1:0] clr_cnt_reg;

    // line stepper (stage A)
    logic [DOT_W-1:0]  x_reg, y_reg, xe_reg, ye_reg;
    logic [DOT_W-1:0]  dx_reg, dy_reg;
    logic              sx_neg_reg, sy_neg_reg;
    logic signed [8:0] err_reg;

    // update stage (stage B)
    logic               b_valid_reg;
    logic [DOT_W-1:0]   b_x_reg, b_y_reg;
    logic               b_last_reg, b_inside_reg;
    logic [CELL_AW-1:0] b_idx_reg;
    logic [PAT_W-1:0]   rd_data_reg;
    logic               fwd_reg;
    logic [PAT_W-1:0]   fwd_data_reg;

    // output registers
    logic             valid_reg;
    logic [DOT_W-1:0] dot_x_reg, dot_y_reg;
    logic [PAT_W-1:0] pattern_reg;
    logic             written_reg, last_reg;

    // cell store
    logic [PAT_W-1:0] cell_mem [CELL_DEPTH];

    logic               accept;
    logic               fin;
    logic [COL_W-1:0]   col_a;
    logic [ROW_W-1:0]   row_a;
    logic [LIM_W-1:0]   lim_c, lim_r;
    logic               inside_a;
    logic [CELL_AW-1:0] idx_a;

    logic signed [9:0]  e2, dx_s, dy_s;
    logic               step_x, step_y;
    logic signed [8:0]  err_next;
    logic [DOT_W-1:0]   x_next, y_next;

    logic [PAT_W-1:0]   b_base, b_pat;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [PAT_W-1:0]   mem_wdata;

    logic [DOT_W-1:0]   abs_dx, abs_dy;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    // endpoint deltas, taken straight from the request
    assign abs_dx = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    assign abs_dy = (end_y > start_y) ? end_y - start_y : start_y - end_y;

    // ---------------- stage A: current dot, cell lookup, step ----------------
    assign fin   = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign col_a = x_reg[DOT_W-1:1];
    assign row_a = y_reg[DOT_W-1:2];

    // canvas limits, capped at the storage size
    assign lim_c = (LIM_W'(cols_reg) < LIM_W'(MAX_COLS)) ? LIM_W'(cols_reg)
                                                         : LIM_W'(MAX_COLS);
    assign lim_r = (LIM_W'(rows_reg) < LIM_W'(MAX_ROWS)) ? LIM_W'(rows_reg)
                                                         : LIM_W'(MAX_ROWS);
    assign inside_a = (LIM_W'(col_a) < lim_c) && (LIM_W'(row_a) < lim_r);

    assign idx_a = CELL_AW'(CELL_AW'(row_a) * CELL_AW'(MAX_COLS) + CELL_AW'(col_a));

    // Bresenham decision: e2 = 2*err against -dy and dx
    assign dx_s   = $signed({4'b0000, dx_reg});
    assign dy_s   = $signed({4'b0000, dy_reg});
    assign e2     = {err_reg, 1'b0};
    assign step_x = (e2 > -dy_s);
    assign step_y = (e2 < dx_s);

    always_comb
    begin
        err_next = err_reg;
        if (step_x)
        begin
            err_next = err_next - $signed({3'b000, dy_reg});
        end
        if (step_y)
        begin
            err_next = err_next + $signed({3'b000, dx_reg});
        end
    end

    assign x_next = step_x ? (sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1) : x_reg;
    assign y_next = step_y ? (sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1) : y_reg;

    // ---------------- stage B: OR in the dot and write back ----------------
    // bypass: the previous dot wrote this cell in the same cycle it was read
    assign b_base = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign b_pat  = b_base | braille_bit(b_y_reg[1:0], b_x_reg[0]);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = b_valid_reg && b_inside_reg;
            mem_waddr = b_idx_reg;
            mem_wdata = b_pat;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CELL_AW'(CELL_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fin)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cols_reg    <= COLS_W'(32);
            rows_reg    <= ROWS_W'(16);
            clr_cnt_reg <= '0;
            b_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CANVAS_COLS: cols_reg <= cfg_data[COLS_W-1:0];
                    REG_CANVAS_ROWS: rows_reg <= cfg_data[ROWS_W-1:0];
                    default:         ;
                endcase
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            b_valid_reg <= (state_reg == ST_RUN);
            valid_reg   <= b_valid_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= start_x;
            y_reg      <= start_y;
            xe_reg     <= end_x;
            ye_reg     <= end_y;
            dx_reg     <= abs_dx;
            dy_reg     <= abs_dy;
            sx_neg_reg <= !(start_x < end_x);
            sy_neg_reg <= !(start_y < end_y);
            err_reg    <= $signed({3'b000, abs_dx}) - $signed({3'b000, abs_dy});
        end
        else if (state_reg == ST_RUN && !fin)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end

        // stage A -> B
        b_x_reg      <= x_reg;
        b_y_reg      <= y_reg;
        b_last_reg   <= fin;
        b_inside_reg <= inside_a;
        b_idx_reg    <= idx_a;
        fwd_reg      <= b_valid_reg && b_inside_reg && (b_idx_reg == idx_a);
        fwd_data_reg <= b_pat;

        // stage B -> result
        dot_x_reg   <= b_x_reg;
        dot_y_reg   <= b_y_reg;
        pattern_reg <= b_inside_reg ? b_pat : '0;
        written_reg <= b_inside_reg;
        last_reg    <= b_last_reg;
    end

    // cell store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[idx_a];
    end

    assign valid    = valid_reg;
    assign dot_x    = dot_x_reg;
    assign dot_y    = dot_y_reg;
    assign cell_col = dot_x_reg[DOT_W-1:1];
    assign cell_row = dot_y_reg[DOT_W-1:2];
    assign pattern  = pattern_reg;
    assign written  = written_reg;
    assign last     = last_reg;

endmodule

FILE: hdl/blr_checker.sv
module blr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            valid,
    input logic [blr_pkg::DOT_W-1:0]       dot_x,
    input logic [blr_pkg::DOT_W-1:0]       dot_y,
    input logic [blr_pkg::PAT_W-1:0]       pattern,
    input logic                            written,
    input logic                            last
);
    import blr_pkg::*;

    // request taken -> block busy next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // dots of a line come out on consecutive cycles
    a_dots_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |=> valid)
        else $error("gap inside a line");

    // a new line's first dot never follows the last dot directly
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !valid)
        else $error("result right after last dot");

    // outside dots report an empty pattern
    a_outside_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !written |-> pattern == '0)
        else $error("pattern set for unwritten dot");

    // a written cell holds this dot's bit
    a_dot_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
        valid && written |-> (pattern & braille_bit(dot_y[1:0], dot_x[0])) != '0)
        else $error("dot bit missing from pattern");

endmodule

bind braille_line_rasterizer blr_checker u_blr_checker (.*);
